// File: rtl/core/tmwf_pkg.sv
// ----------------------------------------------------------------------------
// tmwf_pkg: shared types and constants of the trimmed mean window filter
// Window geometry, rank range, register map and the cell link structs.
// ----------------------------------------------------------------------------
package tmwf_pkg;

  // Window and trimming geometry
  localparam int WINDOW_LEN = 10;
  localparam int RANK_FIRST = 3;
  localparam int RANK_COUNT = 4;
  localparam int AGE_W      = $clog2(WINDOW_LEN);
  localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WINDOW_LEN - 1);

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 12;
  localparam int BOUND_W  = 15;

  // Register map (word index on paddr[3:2])
  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_LEFT_GAIN    = 2'd0;
  localparam logic [1:0] REG_RIGHT_GAIN   = 2'd1;
  localparam logic [1:0] REG_OUTPUT_BOUND = 2'd2;

  localparam logic [GAIN_W-1:0]  LEFT_GAIN_RST    = GAIN_W'(256);
  localparam logic [GAIN_W-1:0]  RIGHT_GAIN_RST   = GAIN_W'(256);
  localparam logic [BOUND_W-1:0] OUTPUT_BOUND_RST = BOUND_W'(32767);

  // One sorted entry; inf marks the empty slot above the top of the list
  typedef struct packed {
    logic                       inf;
    logic signed [SAMPLE_W-1:0] value;
    logic [AGE_W-1:0]           age;
  } entry_t;

  // Link from a cell to the one above it
  typedef struct packed {
    logic   del_seen;  // oldest entry sits at or below this cell
    entry_t r;         // compacted entry at this position
    logic   r_le_x;    // compacted entry is not above the new sample
  } link_t;

  // Configuration register set
  typedef struct packed {
    logic [GAIN_W-1:0]  left_gain;
    logic [GAIN_W-1:0]  right_gain;
    logic [BOUND_W-1:0] output_bound;
  } cfg_t;

endpackage

// File: rtl/core/tmwf_cell.sv
// ----------------------------------------------------------------------------
// tmwf_cell: one slot of the sorted window chain
// Holds one value and its age; drops the oldest and inserts the new sample
// using only its two neighbors.
// ----------------------------------------------------------------------------
module tmwf_cell
  import tmwf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift_en,
  input  logic [AGE_W-1:0]           init_age,
  input  logic signed [SAMPLE_W-1:0] x,
  input  entry_t                     upper,
  input  link_t                      lo_link,
  output link_t                      hi_link,
  output entry_t                     cur
);

  logic signed [SAMPLE_W-1:0] value_r, value_nxt;
  logic [AGE_W-1:0]           age_r, age_nxt;
  logic                       del_here;
  logic                       seen;
  entry_t                     r;
  logic                       r_le_x;

  assign cur = '{inf: 1'b0, value: value_r, age: age_r};

  // Compaction: above the dropped entry, take the upper neighbor's entry
  assign del_here = (age_r == AGE_OLDEST);
  assign seen     = lo_link.del_seen | del_here;
  assign r        = seen ? upper : cur;
  assign r_le_x   = !r.inf && ($signed(r.value) <= $signed(x));

  assign hi_link = '{del_seen: seen, r: r, r_le_x: r_le_x};

  // Insertion: keep own, take new sample, or take the lower entry
  always_comb begin
    if (r_le_x) begin
      value_nxt = r.value;
      age_nxt   = r.age + AGE_W'(1);
    end else if (lo_link.r_le_x) begin
      value_nxt = x;
      age_nxt   = '0;
    end else begin
      value_nxt = lo_link.r.value;
      age_nxt   = lo_link.r.age + AGE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
      age_r   <= init_age;
    end else if (shift_en) begin
      value_r <= value_nxt;
      age_r   <= age_nxt;
    end
  end

endmodule

// File: rtl/core/tmwf_cfg.sv
// ----------------------------------------------------------------------------
// tmwf_cfg: configuration register block
// APB-style write and read of gains and output bound.
// ----------------------------------------------------------------------------
module tmwf_cfg
  import tmwf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  cfg_t       cfg_r, cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg        = cfg_r;

  // Write decode; unknown index leaves the registers alone
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_LEFT_GAIN:    cfg_nxt.left_gain    = cfg_pwdata[GAIN_W-1:0];
        REG_RIGHT_GAIN:   cfg_nxt.right_gain   = cfg_pwdata[GAIN_W-1:0];
        REG_OUTPUT_BOUND: cfg_nxt.output_bound = cfg_pwdata[BOUND_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_LEFT_GAIN:    cfg_prdata = {{(32-GAIN_W){1'b0}}, cfg_r.left_gain};
      REG_RIGHT_GAIN:   cfg_prdata = {{(32-GAIN_W){1'b0}}, cfg_r.right_gain};
      REG_OUTPUT_BOUND: cfg_prdata = {{(32-BOUND_W){1'b0}}, cfg_r.output_bound};
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{left_gain: LEFT_GAIN_RST, right_gain: RIGHT_GAIN_RST,
                 output_bound: OUTPUT_BOUND_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/core/trimmed_mean_window_filter.sv
// ----------------------------------------------------------------------------
// trimmed_mean_window_filter: trimmed mean over a sliding window of samples
// A sorted chain of cells keeps the window in rank order; the middle ranks
// are summed in whole units, gained by sign, divided by 4 and clamped.
//
//   channel  dir  payload                     handshake
//   in_      in   tdata[15:0] sample (Q8.8)   tvalid/tready
//   out_     out  tdata[15:0] filtered (Q8.8) tvalid/tready
//   cfg_     in   gains, bound (APB)          psel/penable, pready=1
//
// One item per cycle sustained while out_tready keeps the output draining;
// the chain updates at the accepting edge, then the rank sum, gain multiply,
// and divide and clamp are registered in turn into units_r, prod_r and out_r.
// Each stage holds its item while the next one is stalled.
// Reset (synchronous, active low) zeroes the window and loads register
// defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module trimmed_mean_window_filter
  import tmwf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [15:0] filtered
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int UNITS_W = 12;
  localparam int ACC_W   = UNITS_W + 8;
  localparam int PROD_W  = UNITS_W + GAIN_W + 1;
  localparam int QUOT_W  = PROD_W - 2;

  cfg_t cfg;

  tmwf_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Pipeline handshake
  logic v0_r, v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  logic acc_in, adv1, adv2, adv3;

  assign rdy3      = !v3_r | out_tready;
  assign rdy2      = !v2_r | rdy3;
  assign rdy1      = !v1_r | rdy2;
  assign in_tready = !v0_r | rdy1;
  assign acc_in    = in_tvalid & in_tready;
  assign adv1      = v0_r & rdy1;
  assign adv2      = v1_r & rdy2;
  assign adv3      = v2_r & rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (acc_in)     v0_r <= 1'b1;
      else if (adv1)  v0_r <= 1'b0;
      if (adv1)       v1_r <= 1'b1;
      else if (adv2)  v1_r <= 1'b0;
      if (adv2)       v2_r <= 1'b1;
      else if (adv3)  v2_r <= 1'b0;
      if (adv3)       v3_r <= 1'b1;
      else if (out_tready) v3_r <= 1'b0;
    end
  end

  // Sorted cell chain, smallest at index 0
  logic signed [SAMPLE_W-1:0] x;
  entry_t cur   [WINDOW_LEN];
  entry_t upper [WINDOW_LEN];
  link_t  link  [WINDOW_LEN+1];

  assign x       = $signed(in_tdata);
  assign link[0] = '{del_seen: 1'b0, r: '0, r_le_x: 1'b1};

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    if (i == WINDOW_LEN - 1) begin : g_top
      assign upper[i] = '{inf: 1'b1, value: '0, age: '0};
    end else begin : g_mid
      assign upper[i] = cur[i+1];
    end

    tmwf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (acc_in),
      .init_age (AGE_W'(i)),
      .x        (x),
      .upper    (upper[i]),
      .lo_link  (link[i]),
      .hi_link  (link[i+1]),
      .cur      (cur[i])
    );
  end

  // Stage 1: whole-unit sum of the middle ranks, truncated after each add
  logic signed [UNITS_W-1:0] units_r, units_nxt;

  always_comb begin
    logic signed [ACC_W-1:0]   t;
    logic signed [UNITS_W-1:0] q;
    units_nxt = '0;
    for (int k = RANK_FIRST; k < RANK_FIRST + RANK_COUNT; k++) begin
      t = $signed({units_nxt, 8'h00})
        + ACC_W'($signed(cur[k].value));
      q = t[ACC_W-1:8];
      if (t[ACC_W-1] && (t[7:0] != 8'h00)) q = q + UNITS_W'(1);
      units_nxt = q;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) units_r <= units_nxt;
  end

  // Stage 2: gain by sign of the average
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [GAIN_W-1:0]        gain_sel;

  assign gain_sel = units_r[UNITS_W-1] ? cfg.right_gain : cfg.left_gain;
  assign prod_nxt = PROD_W'($signed(units_r)) * $signed({1'b0, gain_sel});

  always_ff @(posedge clk) begin
    if (adv2) prod_r <= prod_nxt;
  end

  // Stage 3: divide by 4 toward zero, clamp to the bound
  logic signed [QUOT_W-1:0] quot;
  logic signed [QUOT_W-1:0] bnd;
  logic signed [QUOT_W-1:0] clamped;
  logic [15:0]              out_r;

  always_comb begin
    quot = prod_r[PROD_W-1:2];
    if (prod_r[PROD_W-1] && (prod_r[1:0] != 2'b00)) quot = quot + QUOT_W'(1);
    bnd = $signed({{(QUOT_W-BOUND_W){1'b0}}, cfg.output_bound});
    if (quot > bnd)       clamped = bnd;
    else if (quot < -bnd) clamped = -bnd;
    else                  clamped = quot;
  end

  always_ff @(posedge clk) begin
    if (adv3) out_r <= clamped[15:0];
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = out_r;

endmodule
